FILE: src/gmt_pkg.sv
// Shared types, constants and helper functions of the group membership table.
package gmt_pkg;

  localparam int GROUPS = 16;
  localparam int SLOTS  = 16;
  localparam int IDS    = 256;

  localparam int GIDX_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ID_W       = (IDS > 1) ? $clog2(IDS) : 1;
  localparam int COUNT_W    = $clog2(SLOTS + 1);
  localparam int OWNER_W    = $clog2(GROUPS + 1);
  localparam int MDEPTH     = GROUPS * SLOTS;
  localparam int MADDR_W    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

  localparam logic [OWNER_W-1:0] OWNER_NONE = OWNER_W'(GROUPS);

  localparam int OP_W        = 2;
  localparam int IN_GRP_W    = 4;
  localparam int IN_ID_W     = 8;
  localparam int IN_SLOT_W   = 4;
  localparam int STATUS_W    = 2;
  localparam int OUT_COUNT_W = 5;
  localparam int OUT_RID_W   = 8;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_GROUP = 2'd2,
    ST_BEYOND   = 2'd3
  } status_e;

  typedef struct packed {
    op_e                  op;
    logic [IN_GRP_W-1:0]  grp;
    logic [IN_ID_W-1:0]   member_id;
    logic [IN_SLOT_W-1:0] slot;
    logic                 batch_end;
  } in_item_t;

  typedef struct packed {
    status_e                status;
    logic [OUT_COUNT_W-1:0] count;
    logic [OUT_RID_W-1:0]   read_id;
    logic                   batch_done;
  } res_t;

  typedef struct packed {
    logic               we;
    logic [MADDR_W-1:0] waddr;
    logic [ID_W-1:0]    wdata;
    logic [MADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic               we;
    logic [ID_W-1:0]    waddr;
    logic [OWNER_W-1:0] wdata;
    logic [ID_W-1:0]    raddr;
  } own_req_t;

  function automatic logic [GIDX_W-1:0] grp_reduce(input logic [IN_GRP_W-1:0] g);
    logic [GIDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**IN_GRP_W; i++) begin
      if (g == IN_GRP_W'(i)) r = GIDX_W'(i % GROUPS);
    end
    return r;
  endfunction

  function automatic logic [ID_W-1:0] id_reduce(input logic [IN_ID_W-1:0] id);
    logic [ID_W-1:0] r;
    r = '0;
    for (int i = 0; i < 2**IN_ID_W; i++) begin
      if (id == IN_ID_W'(i)) r = ID_W'(i % IDS);
    end
    return r;
  endfunction

  function automatic logic [MADDR_W-1:0] maddr(input logic [GIDX_W-1:0] grp,
                                               input logic [SLOT_IDX_W-1:0] s);
    return MADDR_W'(int'(grp) * SLOTS + int'(s));
  endfunction

endpackage

FILE: src/group_membership_table.sv
// Top level of the group membership table: memories, sequencer and result register.
// One transaction is worked on at a time. A clear walks its own group in the member memory;
// a remove, or an add of an id that is in a group, walks that id's group, one entry per cycle.
// The result register lets the next transaction be accepted while a result waits.
// After reset the owner memory is swept, one entry per cycle, before the
// first transaction is accepted; group counts clear at once.
module group_membership_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: grp[3:0], member_id[11:4], slot[15:12].
  input  logic [gmt_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // Fields from bit 0: op[1:0].
  input  logic [gmt_pkg::OP_W-1:0]            s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: count[4:0], read_id[12:5], zero fill[15:13].
  output logic [gmt_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [gmt_pkg::STATUS_W-1:0]        m_axis_tuser,
  output logic                                m_axis_tlast
);
  import gmt_pkg::*;

  in_item_t           in_item;
  res_t               res;
  logic               res_valid;
  logic               res_ready;
  mem_req_t           mem_req;
  own_req_t           own_req;
  logic [ID_W-1:0]    mem_rdata;
  logic [OWNER_W-1:0] own_rdata;
  logic               out_valid_q;
  res_t               out_q;

  assign in_item.op        = op_e'(s_axis_tuser);
  assign in_item.grp       = s_axis_tdata[3:0];
  assign in_item.member_id = s_axis_tdata[11:4];
  assign in_item.slot      = s_axis_tdata[15:12];
  assign in_item.batch_end = s_axis_tlast;

  gmt_ram #(
    .WIDTH(ID_W),
    .DEPTH(MDEPTH)
  ) u_member_ram (
    .clk_i  (clk_i),
    .we_i   (mem_req.we),
    .waddr_i(mem_req.waddr),
    .wdata_i(mem_req.wdata),
    .raddr_i(mem_req.raddr),
    .rdata_o(mem_rdata)
  );

  gmt_ram #(
    .WIDTH(OWNER_W),
    .DEPTH(IDS)
  ) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (own_req.we),
    .waddr_i(own_req.waddr),
    .wdata_i(own_req.wdata),
    .raddr_i(own_req.raddr),
    .rdata_o(own_rdata)
  );

  gmt_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_o      (mem_req),
    .mem_rdata_i(mem_rdata),
    .own_o      (own_req),
    .own_rdata_i(own_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q.read_id, out_q.count};
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.batch_done;

endmodule

FILE: src/gmt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module gmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/gmt_core.sv
// Operation sequencer: walks the member and owner memories and keeps the group counts.
module gmt_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gmt_pkg::in_item_t in_item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output gmt_pkg::res_t     res_o,
  output gmt_pkg::mem_req_t mem_o,
  input  logic [gmt_pkg::ID_W-1:0]    mem_rdata_i,
  output gmt_pkg::own_req_t own_o,
  input  logic [gmt_pkg::OWNER_W-1:0] own_rdata_i
);
  import gmt_pkg::*;

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_CLR     = 10'b0000000100,
    S_ADD_OWN = 10'b0000001000,
    S_REM_OWN = 10'b0000010000,
    S_TK_SRCH = 10'b0000100000,
    S_TK_MOVE = 10'b0001000000,
    S_ADD_APP = 10'b0010000000,
    S_RD_DATA = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_e;

  state_e               state_q, state_d;
  logic [ID_W-1:0]      init_q, init_d;
  logic [COUNT_W-1:0]   idx_q, idx_d;
  logic [COUNT_W-1:0]   pidx_q, pidx_d;
  logic [COUNT_W-1:0]   fidx_q, fidx_d;
  logic                 pend_q, pend_d;
  logic                 found_q, found_d;
  logic [GIDX_W-1:0]    og_q, og_d;
  logic [COUNT_W-1:0]   count_q [GROUPS];

  op_e                  op_q;
  logic [GIDX_W-1:0]    g_q;
  logic [ID_W-1:0]      id_q;
  logic [IN_SLOT_W-1:0] slot_q;
  logic                 batch_q;
  status_e              status_q, status_d;
  logic [COUNT_W-1:0]   rescnt_q, rescnt_d;
  logic [ID_W-1:0]      rid_q, rid_d;

  logic                 load_in;
  logic                 cnt_we;
  logic [COUNT_W-1:0]   cnt_wdata;
  logic [GIDX_W-1:0]    cur_grp;
  logic [COUNT_W-1:0]   cnt_rd;
  logic [COUNT_W-1:0]   n_last;

  assign cur_grp = (state_q inside {S_TK_SRCH, S_TK_MOVE}) ? og_q : g_q;
  assign cnt_rd  = count_q[cur_grp];
  assign n_last  = cnt_rd - COUNT_W'(1);

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    fidx_d      = fidx_q;
    pend_d      = 1'b0;
    found_d     = found_q;
    og_d        = og_q;
    status_d    = status_q;
    rescnt_d    = rescnt_q;
    rid_d       = rid_q;
    load_in     = 1'b0;
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    mem_o       = '0;
    own_o       = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      S_INIT: begin
        own_o.we    = 1'b1;
        own_o.waddr = init_q;
        own_o.wdata = OWNER_NONE;
        if (init_q == ID_W'(IDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          init_d = init_q + ID_W'(1);
        end
      end
      S_IDLE: begin
        in_ready_o  = 1'b1;
        own_o.raddr = id_reduce(in_item_i.member_id);
        mem_o.raddr = maddr(grp_reduce(in_item_i.grp), SLOT_IDX_W'(in_item_i.slot));
        if (in_valid_i) begin
          load_in  = 1'b1;
          idx_d    = '0;
          found_d  = 1'b0;
          status_d = ST_OK;
          rid_d    = '0;
          case (in_item_i.op)
            OP_CLEAR:  state_d = S_CLR;
            OP_ADD:    state_d = S_ADD_OWN;
            OP_REMOVE: state_d = S_REM_OWN;
            default:   state_d = S_RD_DATA;
          endcase
        end
      end
      S_CLR: begin
        if (pend_q) begin
          own_o.we    = 1'b1;
          own_o.waddr = mem_rdata_i;
          own_o.wdata = OWNER_NONE;
        end
        if (idx_q < cnt_rd) begin
          mem_o.raddr = maddr(g_q, idx_q[SLOT_IDX_W-1:0]);
          idx_d       = idx_q + COUNT_W'(1);
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          cnt_we    = 1'b1;
          cnt_wdata = '0;
          rescnt_d  = '0;
          state_d   = S_DONE;
        end
      end
      S_ADD_OWN: begin
        if (cnt_rd >= COUNT_W'(SLOTS)) begin
          status_d = ST_FULL;
          rescnt_d = cnt_rd;
          state_d  = S_DONE;
        end else if (own_rdata_i < OWNER_NONE) begin
          og_d    = own_rdata_i[GIDX_W-1:0];
          state_d = S_TK_SRCH;
        end else begin
          state_d = S_ADD_APP;
        end
      end
      S_REM_OWN: begin
        if (own_rdata_i >= OWNER_NONE) begin
          status_d = ST_NO_GROUP;
          rescnt_d = '0;
          state_d  = S_DONE;
        end else begin
          og_d    = own_rdata_i[GIDX_W-1:0];
          state_d = S_TK_SRCH;
        end
      end
      S_TK_SRCH: begin
        if (pend_q && (mem_rdata_i == id_q)) begin
          found_d     = 1'b1;
          fidx_d      = pidx_q;
          mem_o.raddr = maddr(og_q, n_last[SLOT_IDX_W-1:0]);
          state_d     = S_TK_MOVE;
        end else if (idx_q < cnt_rd) begin
          mem_o.raddr = maddr(og_q, idx_q[SLOT_IDX_W-1:0]);
          pidx_d      = idx_q;
          idx_d       = idx_q + COUNT_W'(1);
          pend_d      = 1'b1;
        end else if (!pend_q) begin
          state_d = S_TK_MOVE;
        end
      end
      S_TK_MOVE: begin
        own_o.we    = 1'b1;
        own_o.waddr = id_q;
        own_o.wdata = OWNER_NONE;
        if (found_q) begin
          cnt_we    = 1'b1;
          cnt_wdata = n_last;
          rescnt_d  = n_last;
          if (fidx_q != n_last) begin
            mem_o.we    = 1'b1;
            mem_o.waddr = maddr(og_q, fidx_q[SLOT_IDX_W-1:0]);
            mem_o.wdata = mem_rdata_i;
          end
        end else begin
          rescnt_d = cnt_rd;
        end
        state_d = (op_q == OP_ADD) ? S_ADD_APP : S_DONE;
      end
      S_ADD_APP: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = maddr(g_q, cnt_rd[SLOT_IDX_W-1:0]);
        mem_o.wdata = id_q;
        own_o.we    = 1'b1;
        own_o.waddr = id_q;
        own_o.wdata = OWNER_W'(g_q);
        cnt_we      = 1'b1;
        cnt_wdata   = cnt_rd + COUNT_W'(1);
        rescnt_d    = cnt_rd + COUNT_W'(1);
        state_d     = S_DONE;
      end
      S_RD_DATA: begin
        rescnt_d = cnt_rd;
        if ((int'(slot_q) >= int'(cnt_rd)) || (int'(slot_q) >= SLOTS)) begin
          status_d = ST_BEYOND;
        end else begin
          rid_d = mem_rdata_i;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      for (int i = 0; i < GROUPS; i++) begin
        count_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      if (cnt_we) begin
        count_q[cur_grp] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    fidx_q   <= fidx_d;
    og_q     <= og_d;
    status_q <= status_d;
    rescnt_q <= rescnt_d;
    rid_q    <= rid_d;
    if (load_in) begin
      op_q    <= in_item_i.op;
      g_q     <= grp_reduce(in_item_i.grp);
      id_q    <= id_reduce(in_item_i.member_id);
      slot_q  <= in_item_i.slot;
      batch_q <= in_item_i.batch_end;
    end
  end

  assign res_o.status     = status_q;
  assign res_o.count      = OUT_COUNT_W'(rescnt_q);
  assign res_o.read_id    = OUT_RID_W'(rid_q);
  assign res_o.batch_done = batch_q;

endmodule

FILE: src/gmt_checker.sv
// Port-level assertions for the group membership table and their bind statement.
module gmt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [gmt_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [gmt_pkg::STATUS_W-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);
  import gmt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Result changed while stalled.");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input accepted while a transaction is still in progress.");

  a_rid_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[12:5] == '0)
    else $error("Read id is nonzero on an error status.");

  a_no_group_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NO_GROUP) |-> m_axis_tdata[4:0] == '0)
    else $error("Count is nonzero for an ungrouped id.");

endmodule

bind group_membership_table gmt_checker u_gmt_checker (.*);

FILE: sim/testbench.sv
// Self-checking testbench for the group membership table: directed table, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gmt_pkg::*;

  localparam int ITEMS       = 1050;
  localparam int MAX_GAP     = 17;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 1500;
  localparam int PRINT_CAP   = 200;

  typedef struct {
    in_item_t item;
    int       reps;
    bit       typed;
    res_t     want;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [OP_W-1:0]      s_axis_tuser;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;
  logic                 m_axis_tlast;

  logic [ID_W-1:0]    roster    [MDEPTH];
  logic [COUNT_W-1:0] headcount [GROUPS];
  logic [OWNER_W-1:0] owner_of  [IDS];

  res_t      owed_q [$];
  plan_row_t plan_q [$];

  int  faults;
  int  sent;
  int  checked;
  int  drains;
  int  op_seen [4];
  int  status_seen [4];
  bit  calm_tx;
  bit  calm_rx;

  group_membership_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void evict(input int id);
    int  g;
    int  n;
    bit  hit;
    g = owner_of[id];
    if (g < GROUPS) begin
      n = headcount[g];
      hit = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        if (roster[g * SLOTS + i] == ID_W'(id)) begin
          hit = 1'b1;
          if (i < n - 1) begin
            roster[g * SLOTS + i] = roster[g * SLOTS + n - 1];
          end
          headcount[g] = COUNT_W'(n - 1);
        end
      end
    end
    owner_of[id] = OWNER_NONE;
  endfunction

  function automatic res_t apply_op(input in_item_t it);
    res_t r;
    int   g;
    int   id;
    int   n;
    int   og;
    g  = int'(it.grp) % GROUPS;
    id = int'(it.member_id) % IDS;
    r.status     = ST_OK;
    r.count      = '0;
    r.read_id    = '0;
    r.batch_done = it.batch_end;
    case (it.op)
      OP_CLEAR: begin
        for (int i = 0; i < int'(headcount[g]) && i < SLOTS; i++) begin
          owner_of[int'(roster[g * SLOTS + i]) % IDS] = OWNER_NONE;
        end
        headcount[g] = '0;
      end
      OP_ADD: begin
        if (int'(headcount[g]) >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          if (owner_of[id] != OWNER_NONE) evict(id);
          n = headcount[g];
          roster[g * SLOTS + n] = ID_W'(id);
          headcount[g] = COUNT_W'(n + 1);
          owner_of[id] = OWNER_W'(g);
        end
        r.count = OUT_COUNT_W'(headcount[g]);
      end
      OP_REMOVE: begin
        og = owner_of[id];
        if (og >= GROUPS) begin
          r.status = ST_NO_GROUP;
        end else begin
          evict(id);
          r.count = OUT_COUNT_W'(headcount[og]);
        end
      end
      default: begin
        r.count = OUT_COUNT_W'(headcount[g]);
        if (int'(it.slot) >= int'(headcount[g]) || int'(it.slot) >= SLOTS) begin
          r.status = ST_BEYOND;
        end else begin
          r.read_id = OUT_RID_W'(roster[g * SLOTS + int'(it.slot)]);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int hot_group();
    return ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, GROUPS - 1);
  endfunction

  function automatic int pick_id();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 47) : $urandom_range(0, 255);
  endfunction

  task automatic send(input in_item_t it, input bit typed, input res_t want);
    int   gap;
    res_t predicted;
    if (sent % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    gap = calm_tx ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {it.slot, it.member_id, it.grp};
    s_axis_tuser  = it.op;
    s_axis_tlast  = it.batch_end;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_op(it);
    owed_q.push_back(typed ? want : predicted);
    op_seen[int'(it.op)]++;
    sent++;
    @(negedge clk_i);
  endtask

  task automatic post(input op_e op, input int g, input int id, input int slot, input bit last);
    in_item_t it;
    res_t     none;
    it.op        = op;
    it.grp       = IN_GRP_W'(g);
    it.member_id = IN_ID_W'(id);
    it.slot      = IN_SLOT_W'(slot);
    it.batch_end = last;
    none         = '0;
    send(it, 1'b0, none);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (owed_q.size() != 0) @(negedge clk_i);
    drains++;
  endtask

  task automatic plan(input op_e op, input int g, input int id, input int slot, input bit last,
                      input int reps, input bit typed, input status_e st, input int cnt,
                      input int rid);
    plan_row_t row;
    row.item.op           = op;
    row.item.grp          = IN_GRP_W'(g);
    row.item.member_id    = IN_ID_W'(id);
    row.item.slot         = IN_SLOT_W'(slot);
    row.item.batch_end    = last;
    row.reps              = reps;
    row.typed             = typed;
    row.want.status       = st;
    row.want.count        = OUT_COUNT_W'(cnt);
    row.want.read_id      = OUT_RID_W'(rid);
    row.want.batch_done   = last;
    plan_q.push_back(row);
  endtask

  task automatic run_directed();
    in_item_t it;
    plan(OP_READ,    0,   0,  0, 1'b0,  1, 1'b1, ST_BEYOND,   0,   0);
    plan(OP_REMOVE,  0, 255,  0, 1'b1,  1, 1'b1, ST_NO_GROUP, 0,   0);
    plan(OP_CLEAR,  15,   0, 15, 1'b0,  1, 1'b1, ST_OK,       0,   0);
    plan(OP_ADD,    15,   0,  0, 1'b0,  1, 1'b1, ST_OK,       1,   0);
    plan(OP_ADD,    15, 255,  0, 1'b1,  1, 1'b1, ST_OK,       2,   0);
    plan(OP_READ,   15,   0,  1, 1'b0,  1, 1'b1, ST_OK,       2, 255);
    plan(OP_READ,   15,   0, 15, 1'b0,  1, 1'b1, ST_BEYOND,   2,   0);
    // Re-adding a member of the same group moves it to the last slot.
    plan(OP_ADD,    15,   0,  0, 1'b0,  1, 1'b0, ST_OK,       0,   0);
    plan(OP_READ,   15,   0,  0, 1'b0,  1, 1'b0, ST_OK,       0,   0);
    plan(OP_ADD,     3, 255,  0, 1'b0,  1, 1'b0, ST_OK,       0,   0);
    plan(OP_ADD,     7,  16,  0, 1'b0, 16, 1'b0, ST_OK,       0,   0);
    plan(OP_ADD,     7, 255,  0, 1'b1,  1, 1'b1, ST_FULL,    16,   0);
    plan(OP_REMOVE,  0,  20,  0, 1'b0,  1, 1'b0, ST_OK,       0,   0);
    plan(OP_READ,    7,   0,  4, 1'b0,  1, 1'b0, ST_OK,       0,   0);
    plan(OP_CLEAR,   7,   0,  0, 1'b1,  1, 1'b1, ST_OK,       0,   0);
    plan(OP_REMOVE,  0,  31,  0, 1'b0,  1, 1'b1, ST_NO_GROUP, 0,   0);
    foreach (plan_q[i]) begin
      for (int r = 0; r < plan_q[i].reps; r++) begin
        it = plan_q[i].item;
        it.member_id = plan_q[i].item.member_id + IN_ID_W'(r);
        send(it, plan_q[i].typed, plan_q[i].want);
      end
    end
  endtask

  task automatic run_random();
    int pick;
    int g;
    int k;
    int og;
    int id;
    int slot;
    drain();
    while (sent < ITEMS) begin
      if ($urandom_range(0, 59) == 0) drain();
      pick = $urandom_range(0, 99);
      g = hot_group();
      if (pick < 12) begin
        k = $urandom_range(0, SLOTS + 2);
        post(OP_CLEAR, g, $urandom_range(0, 255), $urandom_range(0, 15), k == 0);
        for (int j = 0; j < k; j++) begin
          post(OP_ADD, g, pick_id(), $urandom_range(0, 15), j == k - 1);
        end
      end else if (pick < 50) begin
        post(OP_ADD, g, pick_id(), $urandom_range(0, 15), $urandom_range(0, 1));
      end else if (pick < 72) begin
        og = hot_group();
        if (headcount[og] != 0 && $urandom_range(0, 4) < 3) begin
          id = roster[og * SLOTS + $urandom_range(0, int'(headcount[og]) - 1)];
        end else begin
          id = pick_id();
        end
        post(OP_REMOVE, $urandom_range(0, 15), id, $urandom_range(0, 15), $urandom_range(0, 1));
      end else if (pick < 95) begin
        if (headcount[g] != 0 && $urandom_range(0, 1) == 1) begin
          slot = $urandom_range(0, int'(headcount[g]) - 1);
        end else begin
          slot = $urandom_range(0, 15);
        end
        post(OP_READ, g, $urandom_range(0, 255), slot, $urandom_range(0, 1));
      end else begin
        post(OP_CLEAR, g, $urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1));
      end
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    faults        = 0;
    sent          = 0;
    drains        = 0;
    calm_tx       = 1'b0;
    foreach (roster[i]) roster[i] = '0;
    foreach (headcount[i]) headcount[i] = '0;
    foreach (owner_of[i]) owner_of[i] = OWNER_NONE;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    s_axis_tvalid = 1'b0;
    while (owed_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d transactions (%0d clear, %0d add, %0d remove, %0d read), %0d drains.",
             sent, op_seen[OP_CLEAR], op_seen[OP_ADD], op_seen[OP_REMOVE], op_seen[OP_READ],
             drains);
    $display("Checked %0d results: %0d full drops, %0d ungrouped removes, %0d reads past count.",
             checked, status_seen[ST_FULL], status_seen[ST_NO_GROUP], status_seen[ST_BEYOND]);
    if (faults == 0) begin
      $display("group_membership_table: match");
    end else begin
      $display("group_membership_table: mismatch");
    end
    $finish;
  end

  initial begin : result_sink
    int   stall;
    res_t want;
    res_t seen;
    m_axis_tready = 1'b0;
    checked = 0;
    calm_rx = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (checked % 37 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      stall = calm_rx ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      seen.status     = status_e'(m_axis_tuser);
      seen.count      = m_axis_tdata[4:0];
      seen.read_id    = m_axis_tdata[12:5];
      seen.batch_done = m_axis_tlast;
      checked++;
      if (owed_q.size() == 0) begin
        faults++;
        if (faults <= PRINT_CAP) begin
          $display("%0t: unexpected result status %0d count %0d read_id %0d batch_done %0b",
                   $time, seen.status, seen.count, seen.read_id, seen.batch_done);
        end
      end else begin
        want = owed_q.pop_front();
        status_seen[int'(want.status)]++;
        if (seen !== want) begin
          faults++;
          if (faults <= PRINT_CAP) begin
            $display("%0t: expected status %0d count %0d read_id %0d batch_done %0b, got %s",
                     $time, want.status, want.count, want.read_id, want.batch_done,
                     $sformatf("status %0d count %0d read_id %0d batch_done %0b",
                               seen.status, seen.count, seen.read_id, seen.batch_done));
          end
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
      if (idle >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle, owed_q.size());
        $display("group_membership_table: mismatch");
        $finish;
      end
    end
  end

endmodule

FILE: group_membership_table.f
src/gmt_pkg.sv
src/gmt_ram.sv
src/gmt_core.sv
src/group_membership_table.sv
src/gmt_checker.sv
sim/testbench.sv
